### hdl/assert_macros.svh
// Assertion macros shared by the frame aligner RTL.
// Needs nothing else; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while reset is released.
`define MSFA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MSFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/msfa_pkg.sv
// Shared constants, types and register indexes of the frame aligner.
// No dependencies.
package msfa_pkg;

    localparam int RECEIVERS       = 4;
    localparam int COUNTER_MODULUS = 512;
    localparam int BUFFER_DEPTH    = 1024;
    localparam int HALF_MODULUS    = COUNTER_MODULUS / 2;

    localparam int CTR_W   = 9;
    localparam int FILL_W  = 11;
    localparam int WRAP_W  = CTR_W + 1;
    localparam int ACT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 11;

    localparam int IN_W    = 88;
    localparam int OUT_W   = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd2;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 3'd4;
    localparam logic [FILL_W-1:0] LOW_RESET    = 11'd1;
    localparam logic [FILL_W-1:0] HIGH_RESET   = 11'd768;

    typedef struct packed {
        logic [ACT_W-1:0]  active;
        logic [FILL_W-1:0] low;
        logic [FILL_W-1:0] high;
    } cfg_t;

    typedef struct packed {
        logic                            go;
        logic [RECEIVERS-1:0]            part;
        logic [RECEIVERS-1:0][CTR_W-1:0] ctr;
        logic [RECEIVERS-1:0]            ok;
    } s1_t;

    typedef struct packed {
        logic                            go;
        logic [RECEIVERS-1:0]            part;
        logic [RECEIVERS-1:0][CTR_W-1:0] ctr;
        logic [RECEIVERS-1:0]            ok;
        logic [CTR_W-1:0]                min1;
        logic [CTR_W-1:0]                max1;
        logic signed [WRAP_W-1:0]        min2;
        logic signed [WRAP_W-1:0]        max2;
    } s2_t;

    typedef struct packed {
        logic                            go;
        logic [CTR_W-1:0]                id;
        logic [RECEIVERS-1:0]            part;
        logic [RECEIVERS-1:0][CTR_W-1:0] ctr;
        logic [RECEIVERS-1:0]            ok;
    } s3_t;

    typedef struct packed {
        logic                 proceed;
        logic [CTR_W-1:0]     aligned_id;
        logic [RECEIVERS-1:0] pop_mask;
        logic [RECEIVERS-1:0] good_mask;
    } result_t;

endpackage

### hdl/msfa_cond.sv
// Stage 1: threshold checks and per-receiver participation.
// Depends on msfa_pkg.
module msfa_cond (
    input  logic                                         aclk,
    input  logic                                         en,
    input  msfa_pkg::cfg_t                               cfg,
    input  logic [msfa_pkg::RECEIVERS*msfa_pkg::CTR_W-1:0]  head_counters,
    input  logic [msfa_pkg::RECEIVERS*msfa_pkg::FILL_W-1:0] fill_levels,
    input  logic [msfa_pkg::RECEIVERS-1:0]               head_ok_bits,
    output msfa_pkg::s1_t                                s1
);

    msfa_pkg::s1_t               s1_reg;
    msfa_pkg::s1_t               s1_next;
    logic [msfa_pkg::ACT_W-1:0]  act_n;
    logic                        forced;
    logic                        held;
    logic [msfa_pkg::FILL_W-1:0] fill;
    logic                        act;

    always_comb begin
        act_n = (cfg.active > msfa_pkg::ACT_W'(msfa_pkg::RECEIVERS))
              ? msfa_pkg::ACT_W'(msfa_pkg::RECEIVERS) : cfg.active;
        forced = 1'b0;
        held   = 1'b0;
        fill   = '0;
        act    = 1'b0;
        s1_next.part = '0;
        s1_next.ok   = head_ok_bits;
        for (int i = 0; i < msfa_pkg::RECEIVERS; i++) begin
            fill = fill_levels[i*msfa_pkg::FILL_W +: msfa_pkg::FILL_W];
            act  = msfa_pkg::ACT_W'(i) < act_n;
            s1_next.ctr[i]  = head_counters[i*msfa_pkg::CTR_W +: msfa_pkg::CTR_W];
            s1_next.part[i] = act && (fill != '0);
            if (act && (fill > cfg.high)) begin
                forced = 1'b1;
            end
            if (act && (fill < cfg.low)) begin
                held = 1'b1;
            end
        end
        s1_next.go = (act_n != '0) && (forced || !held);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

### hdl/msfa_span.sv
// Stage 2: plain and wrapped minimum / maximum over participating heads.
// Depends on msfa_pkg.
module msfa_span (
    input  logic          aclk,
    input  logic          en,
    input  msfa_pkg::s1_t s1,
    output msfa_pkg::s2_t s2
);

    msfa_pkg::s2_t                   s2_reg;
    msfa_pkg::s2_t                   s2_next;
    logic [msfa_pkg::CTR_W-1:0]      v;
    logic signed [msfa_pkg::WRAP_W-1:0] w;

    always_comb begin
        s2_next.go   = s1.go && (s1.part != '0);
        s2_next.part = s1.part;
        s2_next.ctr  = s1.ctr;
        s2_next.ok   = s1.ok;
        // start from the far ends so non-participants never win
        s2_next.min1 = '1;
        s2_next.max1 = '0;
        s2_next.min2 = msfa_pkg::WRAP_W'(msfa_pkg::HALF_MODULUS);
        s2_next.max2 = -msfa_pkg::WRAP_W'(msfa_pkg::HALF_MODULUS);
        v = '0;
        w = '0;
        for (int i = 0; i < msfa_pkg::RECEIVERS; i++) begin
            v = s1.ctr[i];
            // counters above half the modulus count as negative
            w = (v > msfa_pkg::CTR_W'(msfa_pkg::HALF_MODULUS))
              ? $signed({1'b0, v} - msfa_pkg::WRAP_W'(msfa_pkg::COUNTER_MODULUS))
              : $signed({1'b0, v});
            if (s1.part[i]) begin
                if (v < s2_next.min1) s2_next.min1 = v;
                if (v > s2_next.max1) s2_next.max1 = v;
                if (w < s2_next.min2) s2_next.min2 = w;
                if (w > s2_next.max2) s2_next.max2 = w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

### hdl/msfa_pick.sv
// Stage 3: spread compare and aligned id selection.
// Depends on msfa_pkg.
module msfa_pick (
    input  logic          aclk,
    input  logic          en,
    input  msfa_pkg::s2_t s2,
    output msfa_pkg::s3_t s3
);

    msfa_pkg::s3_t               s3_reg;
    msfa_pkg::s3_t               s3_next;
    logic [msfa_pkg::WRAP_W-1:0] spread1;
    logic [msfa_pkg::WRAP_W-1:0] spread2;

    always_comb begin
        spread1 = {1'b0, s2.max1} - {1'b0, s2.min1};
        spread2 = $unsigned(s2.max2 - s2.min2);
        s3_next.go   = s2.go;
        s3_next.part = s2.part;
        s3_next.ctr  = s2.ctr;
        s3_next.ok   = s2.ok;
        // tie goes to wrapped order; low bits of a negative minimum add the modulus
        s3_next.id   = (spread1 < spread2) ? s2.min1 : s2.min2[msfa_pkg::CTR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

### hdl/msfa_match.sv
// Stage 4: head match against the aligned id; holds the output register.
// Depends on msfa_pkg.
module msfa_match (
    input  logic              aclk,
    input  logic              en,
    input  msfa_pkg::s3_t     s3,
    output msfa_pkg::result_t res
);

    msfa_pkg::result_t res_reg;
    msfa_pkg::result_t res_next;

    always_comb begin
        res_next.proceed    = s3.go;
        res_next.aligned_id = s3.go ? s3.id : '0;
        res_next.pop_mask   = '0;
        for (int i = 0; i < msfa_pkg::RECEIVERS; i++) begin
            res_next.pop_mask[i] = s3.go && s3.part[i] && (s3.ctr[i] == s3.id);
        end
        res_next.good_mask = res_next.pop_mask & s3.ok;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### hdl/multi_source_frame_aligner_unit.sv
// Frame aligner top level: config registers, stage valids and flow control.
// Depends on msfa_pkg, msfa_cond, msfa_span, msfa_pick, msfa_match, assert_macros.svh.
//
// Usage:
//   s_ channel carries one snapshot of the receiver buffer heads per item:
//   head counters, fill levels and head ok bits. m_ channel returns exactly
//   one decision per item: proceed flag, aligned id, pop mask and good mask.
//   Each accepted item passes four register stages (threshold check,
//   min/max, id select, head match), and m_tvalid is the valid bit of the
//   last one. Throughput is one item per cycle while m_tready stays high;
//   each stage is one register with its own valid bit.
//   When m_tready is low, items pack into empty stages and s_tready drops
//   only once all four stages hold an item; nothing is lost or repeated.
//   The configuration port writes active_receivers (index 0), low_threshold
//   (index 1) and high_threshold (index 2) with no wait; other indexes are
//   ignored. Write it only while no item is in flight.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   registers with 4, 1 and 768.
`include "assert_macros.svh"

module multi_source_frame_aligner_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // head_counters[35:0], fill_levels[79:36], head_ok_bits[83:80], zero fill
    input  logic [msfa_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // proceed[0], aligned_id[9:1], pop_mask[13:10], good_mask[17:14], zero fill
    output logic [msfa_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [msfa_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [msfa_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int CTRS_W  = msfa_pkg::RECEIVERS * msfa_pkg::CTR_W;
    localparam int FILLS_W = msfa_pkg::RECEIVERS * msfa_pkg::FILL_W;
    localparam int RES_W   = 1 + msfa_pkg::CTR_W + 2 * msfa_pkg::RECEIVERS;

    msfa_pkg::cfg_t    cfg_reg;
    msfa_pkg::s1_t     s1;
    msfa_pkg::s2_t     s2;
    msfa_pkg::s3_t     s3;
    msfa_pkg::result_t res;
    logic [3:0]        valid_reg;
    logic [3:0]        en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active <= msfa_pkg::ACTIVE_RESET;
            cfg_reg.low    <= msfa_pkg::LOW_RESET;
            cfg_reg.high   <= msfa_pkg::HIGH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                msfa_pkg::CFG_ACTIVE: cfg_reg.active <= cfg_wdata[msfa_pkg::ACT_W-1:0];
                msfa_pkg::CFG_LOW:    cfg_reg.low    <= cfg_wdata;
                msfa_pkg::CFG_HIGH:   cfg_reg.high   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        en[3] = !valid_reg[3] || m_tready;
        en[2] = !valid_reg[2] || en[3];
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= s_tvalid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
            if (en[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    msfa_cond u_cond (
        .aclk          (aclk),
        .en            (en[0] && s_tvalid),
        .cfg           (cfg_reg),
        .head_counters (s_tdata[CTRS_W-1:0]),
        .fill_levels   (s_tdata[CTRS_W +: FILLS_W]),
        .head_ok_bits  (s_tdata[CTRS_W + FILLS_W +: msfa_pkg::RECEIVERS]),
        .s1            (s1)
    );

    msfa_span u_span (
        .aclk (aclk),
        .en   (en[1] && valid_reg[0]),
        .s1   (s1),
        .s2   (s2)
    );

    msfa_pick u_pick (
        .aclk (aclk),
        .en   (en[2] && valid_reg[1]),
        .s2   (s2),
        .s3   (s3)
    );

    msfa_match u_match (
        .aclk (aclk),
        .en   (en[3] && valid_reg[2]),
        .s3   (s3),
        .res  (res)
    );

    assign m_tvalid = valid_reg[3];
    assign m_tdata  = {{(msfa_pkg::OUT_W - RES_W){1'b0}},
                       res.good_mask, res.pop_mask, res.aligned_id, res.proceed};

    // Good receivers are always among the popped ones.
    `MSFA_ASSERT(a_good_in_pop, aclk, aresetn, m_tvalid |-> ((res.good_mask & ~res.pop_mask) == '0), "good_mask outside pop_mask")
    // A held step reports nothing.
    `MSFA_ASSERT(a_hold_zero, aclk, aresetn, (m_tvalid && !res.proceed) |-> (res.aligned_id == '0 && res.pop_mask == '0), "held step with nonzero fields")
    // The aligned id is some participant's head, so a step pops at least one.
    `MSFA_ASSERT(a_step_pops, aclk, aresetn, (m_tvalid && res.proceed) |-> (res.pop_mask != '0), "step with empty pop_mask")
    // Input is refused only when every stage is full and the output stalls.
    `MSFA_ASSERT(a_ready_full, aclk, aresetn, !s_tready |-> (valid_reg == 4'hF && !m_tready), "stall with a free stage")

endmodule

### dv/multi_source_frame_aligner_unit_test.sv
`timescale 1ns / 1ps
// Testbench for multi_source_frame_aligner_unit: random and directed buffer snapshots,
// with a scoreboard that predicts each step decision. Depends on msfa_pkg and the RTL.
module multi_source_frame_aligner_unit_test;
    import msfa_pkg::*;

    localparam int HEADS_W   = RECEIVERS * CTR_W;
    localparam int FILLS_W   = RECEIVERS * FILL_W;
    localparam int LATENCY   = 4;
    localparam int LIMIT     = 200000;
    localparam int FILL_MAX  = (1 << FILL_W) - 1;
    // index with no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class frame_decision_board;
        logic [ACT_W-1:0]  active_cnt = ACTIVE_RESET;
        logic [FILL_W-1:0] low_thr    = LOW_RESET;
        logic [FILL_W-1:0] high_thr   = HIGH_RESET;
        result_t           decision_q[$];
        int                errors     = 0;

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_ACTIVE: active_cnt = val[ACT_W-1:0];
                CFG_LOW:    low_thr    = val[FILL_W-1:0];
                CFG_HIGH:   high_thr   = val[FILL_W-1:0];
                default: ;
            endcase
        endfunction

        function result_t decide(logic [HEADS_W-1:0] heads, logic [FILLS_W-1:0] fills,
                                 logic [RECEIVERS-1:0] oks);
            result_t r;
            int      n;
            int      ctr[RECEIVERS];
            int      lvl[RECEIVERS];
            bit      forced;
            bit      held;
            bit      seen;
            int      lo1, hi1, lo2, hi2, w, id;
            r      = '0;
            forced = 0;
            held   = 0;
            seen   = 0;
            lo1 = 0; hi1 = 0; lo2 = 0; hi2 = 0;
            n = (active_cnt > RECEIVERS) ? RECEIVERS : int'(active_cnt);
            for (int i = 0; i < RECEIVERS; i++) begin
                ctr[i] = int'(heads[i*CTR_W +: CTR_W]) % COUNTER_MODULUS;
                lvl[i] = int'(fills[i*FILL_W +: FILL_W]);
            end
            for (int i = 0; i < n; i++) begin
                if (lvl[i] > int'(high_thr)) forced = 1;
                if (lvl[i] < int'(low_thr)) held = 1;
            end
            if (n == 0 || (!forced && held))
                return r;
            // empty buffers count for thresholds only
            for (int i = 0; i < n; i++) begin
                if (lvl[i] != 0) begin
                    w = (ctr[i] > HALF_MODULUS) ? ctr[i] - COUNTER_MODULUS : ctr[i];
                    if (!seen) begin
                        lo1 = ctr[i]; hi1 = ctr[i]; lo2 = w; hi2 = w;
                        seen = 1;
                    end else begin
                        if (ctr[i] < lo1) lo1 = ctr[i];
                        if (ctr[i] > hi1) hi1 = ctr[i];
                        if (w < lo2) lo2 = w;
                        if (w > hi2) hi2 = w;
                    end
                end
            end
            if (!seen)
                return r;
            // equal spread goes to wrapped order
            if ((hi1 - lo1) < (hi2 - lo2)) begin
                id = lo1;
            end else begin
                id = (lo2 < 0) ? lo2 + COUNTER_MODULUS : lo2;
            end
            for (int i = 0; i < n; i++) begin
                if (lvl[i] != 0 && ctr[i] == id) begin
                    r.pop_mask[i]  = 1'b1;
                    r.good_mask[i] = oks[i];
                end
            end
            r.proceed    = 1'b1;
            r.aligned_id = id[CTR_W-1:0];
            return r;
        endfunction

        function void note_snapshot(logic [HEADS_W-1:0] heads, logic [FILLS_W-1:0] fills,
                                    logic [RECEIVERS-1:0] oks);
            decision_q = {decision_q, decide(heads, fills, oks)};
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            result_t want;
            if (decision_q.size() == 0) begin
                $error("decision item with none pending: %h", d);
                errors++;
                return;
            end
            want = decision_q.pop_front();
            if (d[0] !== want.proceed) begin
                $error("proceed: expected %0d, got %0d", want.proceed, d[0]);
                errors++;
            end
            if (d[CTR_W:1] !== want.aligned_id) begin
                $error("aligned_id: expected %0d, got %0d", want.aligned_id, d[CTR_W:1]);
                errors++;
            end
            if (d[CTR_W+RECEIVERS:CTR_W+1] !== want.pop_mask) begin
                $error("pop_mask: expected %b, got %b", want.pop_mask,
                       d[CTR_W+RECEIVERS:CTR_W+1]);
                errors++;
            end
            if (d[CTR_W+2*RECEIVERS:CTR_W+RECEIVERS+1] !== want.good_mask) begin
                $error("good_mask: expected %b, got %b", want.good_mask,
                       d[CTR_W+2*RECEIVERS:CTR_W+RECEIVERS+1]);
                errors++;
            end
        endfunction

        function int outstanding();
            return decision_q.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    frame_decision_board sb = new();
    bit                  calm = 0;
    int                  cycles = 0;

    multi_source_frame_aligner_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random back-pressure, checked at the rising edge
    initial begin
        forever begin
            @(negedge aclk);
            m_tready = calm || ($urandom_range(0, 99) >= 23);
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // called right after a falling edge; returns right after a falling edge
    task automatic send_item(logic [HEADS_W-1:0] heads, logic [FILLS_W-1:0] fills,
                             logic [RECEIVERS-1:0] oks);
        while (!calm && $urandom_range(0, 99) < 23) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = '0;
        s_tdata[HEADS_W-1:0]                           = heads;
        s_tdata[HEADS_W+FILLS_W-1:HEADS_W]             = fills;
        s_tdata[HEADS_W+FILLS_W+RECEIVERS-1:HEADS_W+FILLS_W] = oks;
        do @(posedge aclk); while (!s_tready);
        sb.note_snapshot(heads, fills, oks);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        sb.write_register(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    task automatic configure(logic [CFG_W-1:0] act, logic [CFG_W-1:0] lo,
                             logic [CFG_W-1:0] hi);
        drain();
        write_reg(CFG_ACTIVE, act);
        write_reg(CFG_LOW, lo);
        write_reg(CFG_HIGH, hi);
    endtask

    // levels cluster around the thresholds so both hold-back and force happen
    function automatic logic [FILL_W-1:0] pick_level();
        int lo;
        int hi;
        lo = int'(sb.low_thr);
        hi = int'(sb.high_thr);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FILL_W'($urandom_range(0, FILL_MAX));
            2: return FILL_W'(lo + $urandom_range(0, 2) - 1);
            3: return FILL_W'(hi + $urandom_range(0, 1));
            default: return FILL_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [HEADS_W-1:0] pick_heads();
        logic [HEADS_W-1:0] h;
        int mode;
        int base;
        int spread;
        int c;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return HEADS_W'({$urandom(), $urandom()});
        case (mode)
            1, 2:    base = $urandom_range(COUNTER_MODULUS - 7, COUNTER_MODULUS - 1);
            3:       base = $urandom_range(HALF_MODULUS - 6, HALF_MODULUS + 6);
            default: base = $urandom_range(0, COUNTER_MODULUS - 1);
        endcase
        case ($urandom_range(0, 4))
            0:       spread = 0;
            1:       spread = 2;
            2:       spread = 9;
            3:       spread = 300;
            default: spread = 4;
        endcase
        for (int i = 0; i < RECEIVERS; i++) begin
            // mode 4 builds halves a half-modulus apart: equal spread both ways
            if (mode == 4)
                c = base + $urandom_range(0, 1) * HALF_MODULUS;
            else
                c = base + $urandom_range(0, spread);
            h[i*CTR_W +: CTR_W] = CTR_W'(c % COUNTER_MODULUS);
        end
        return h;
    endfunction

    task automatic random_burst(int count);
        for (int k = 0; k < count; k++)
            send_item(pick_heads(), {pick_level(), pick_level(), pick_level(), pick_level()},
                      RECEIVERS'($urandom_range(0, 15)));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: 4 receivers, low 1, high 768
        send_item('0, '0, '0);
        send_item('1, '1, 4'hF);
        send_item({9'd384, 9'd128, 9'd384, 9'd128}, {4{11'd5}}, 4'b1010);
        send_item({9'd510, 9'd2, 9'd511, 9'd3}, {4{11'd10}}, 4'hF);
        send_item({9'd40, 9'd30, 9'd20, 9'd10}, {4{11'd10}}, 4'b0001);
        send_item({9'd256, 9'd257, 9'd256, 9'd257}, {4{11'd10}}, 4'b0110);
        send_item({9'd7, 9'd7, 9'd9, 9'd1}, {11'd5, 11'd5, 11'd800, 11'd0}, 4'hF);
        send_item({9'd7, 9'd7, 9'd9, 9'd1}, {11'd5, 11'd5, 11'd5, 11'd0}, 4'hF);
        send_item({9'd100, 9'd400, 9'd100, 9'd400}, {4{11'd768}}, 4'b1100);
        send_item({9'd300, 9'd12, 9'd90, 9'd33}, {11'd0, 11'd0, 11'd769, 11'd0}, 4'b0010);
        send_item({9'd7, 9'd8, 9'd7, 9'd7}, {4{11'd1}}, 4'b0101);
        send_item({9'd0, 9'd511, 9'd256, 9'd1}, {11'd1024, 11'd1024, 11'd1024, 11'd1024},
                  4'b1001);
        random_burst(240);

        configure(11'd1, 11'd0, 11'd0);
        write_reg(CFG_SPARE, CFG_W'($urandom_range(0, FILL_MAX)));
        send_item({9'd3, 9'd2, 9'd1, 9'd0}, {11'd9, 11'd9, 11'd9, 11'd1}, 4'hF);
        random_burst(200);

        configure(11'd0, 11'd1, 11'd768);
        random_burst(60);

        // low bits give 7, which acts as the full receiver count
        configure(11'h7FF, 11'd2047, 11'd2047);
        random_burst(150);

        configure(11'd3, 11'd0, 11'd2047);
        send_item(HEADS_W'({$urandom(), $urandom()}), '0, 4'hF);
        calm = 1;
        random_burst(250);
        calm = 0;

        configure(11'd2, 11'd300, 11'd600);
        random_burst(250);

        configure(11'd4, 11'd1024, 11'd1024);
        random_burst(200);

        configure(11'd5, CFG_W'($urandom_range(0, 1024)), CFG_W'($urandom_range(0, 1024)));
        random_burst(250);

        configure(11'd4, 11'd1, 11'd768);
        random_burst(200);

        drain();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### multi_source_frame_aligner_unit.f
+incdir+hdl
hdl/msfa_pkg.sv
hdl/msfa_cond.sv
hdl/msfa_span.sv
hdl/msfa_pick.sv
hdl/msfa_match.sv
hdl/multi_source_frame_aligner_unit.sv
dv/multi_source_frame_aligner_unit_test.sv
